[hdl/http_chunked_body_decoder_unit_defines.svh]
// Assertion macros used by the chunked body decoder checker.
`ifndef HTTP_CHUNKED_BODY_DECODER_UNIT_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CHDEC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CHDEC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/chdec_pkg.sv]
// Types and constants of the chunked body decoder.
`default_nettype none

package chdec_pkg;

  // One raw body byte with its end-of-buffer flag
  typedef struct packed {
    logic [7:0] body_byte;
    logic       end_of_body;
  } chdec_in_t;

  // One decoder result
  typedef struct packed {
    logic       has_data;
    logic [7:0] payload_byte;
    logic [2:0] status;
  } chdec_out_t;

  // Input register contents handed to the decoder FSM
  typedef struct packed {
    logic      valid;
    chdec_in_t item;
  } chdec_in_slot_t;

  // Result produced by the FSM for the output register
  typedef struct packed {
    logic       valid;
    chdec_out_t item;
  } chdec_res_t;

  // Status codes
  localparam logic [2:0] ST_RUN    = 3'd0;
  localparam logic [2:0] ST_DONE   = 3'd1;
  localparam logic [2:0] ST_LINE   = 3'd2;
  localparam logic [2:0] ST_TRUNC  = 3'd3;
  localparam logic [2:0] ST_NOCRLF = 3'd4;

  // Decoder phases
  localparam logic [2:0] PH_SKIP    = 3'd0;
  localparam logic [2:0] PH_SKIP_CR = 3'd1;
  localparam logic [2:0] PH_DIGITS  = 3'd2;
  localparam logic [2:0] PH_REST    = 3'd3;
  localparam logic [2:0] PH_REST_CR = 3'd4;
  localparam logic [2:0] PH_DATA    = 3'd5;
  localparam logic [2:0] PH_DATA_CR = 3'd6;
  localparam logic [2:0] PH_DATA_LF = 3'd7;

  // Characters
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;

endpackage

`default_nettype wire

[hdl/chdec_in_stage.sv]
// Input register of the chunked body decoder.
`default_nettype none

module chdec_in_stage (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  chdec_pkg::chdec_in_t     in_data_i,
  input  logic                     advance_i,
  output chdec_pkg::chdec_in_slot_t slot_o
);
  import chdec_pkg::*;

  logic      valid_q, valid_d;
  chdec_in_t item_q;

  // Hold the registered byte while the FSM cannot consume it
  assign in_stall_o = valid_q && !advance_i;
  assign valid_d    = in_stall_o ? valid_q : in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture the payload on each transfer
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q <= in_data_i;
    end
  end

  assign slot_o.valid = valid_q;
  assign slot_o.item  = item_q;

endmodule

`default_nettype wire

[hdl/chdec_fsm.sv]
// Chunk framing state machine: size line parsing, payload count, CRLF checks.
`default_nettype none

module chdec_fsm #(
  parameter int SIZE_BITS = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      fire_i,
  input  chdec_pkg::chdec_in_slot_t slot_i,
  output chdec_pkg::chdec_res_t     res_o
);
  import chdec_pkg::*;

  logic [2:0]           phase_q, phase_d;
  logic [SIZE_BITS-1:0] left_q, left_d;
  logic                 ovf_q, ovf_d;
  logic                 fin_q, fin_d;

  logic [7:0] b;
  logic       eob;
  logic       is_hex, is_blank, is_cr;
  logic [3:0] nib;

  // Line-byte helper results
  logic [2:0]           lbase;
  logic [2:0]           ln_phase;
  logic [SIZE_BITS-1:0] ln_left, dig_left, left_dec;
  logic                 ln_ovf, dig_ovf;

  logic       has;
  logic [2:0] st;

  assign b   = slot_i.item.body_byte;
  assign eob = slot_i.item.end_of_body;

  // Classify the byte
  always_comb begin
    is_hex = 1'b1;
    nib    = 4'd0;
    if (b >= "0" && b <= "9") begin
      nib = 4'(b - 8'h30);
    end else if (b >= "a" && b <= "f") begin
      nib = 4'(b - 8'h57);
    end else if (b >= "A" && b <= "F") begin
      nib = 4'(b - 8'h37);
    end else begin
      is_hex = 1'b0;
    end
  end

  assign is_cr    = (b == CHAR_CR);
  assign is_blank = (b == CHAR_SPACE) || (b >= CHAR_TAB && b <= CHAR_CR);

  // Accumulate one hex digit, saturating on overflow
  always_comb begin
    dig_left = left_q;
    dig_ovf  = ovf_q;
    if (!ovf_q) begin
      if (left_q[SIZE_BITS-1 -: 4] != 4'd0) begin
        dig_ovf  = 1'b1;
        dig_left = '1;
      end else begin
        dig_left = {left_q[SIZE_BITS-5:0], nib};
      end
    end
  end

  // Size line byte that is not a line end; CR phases fall back to their base
  always_comb begin
    if (phase_q == PH_SKIP_CR) begin
      lbase = PH_SKIP;
    end else if (phase_q == PH_REST_CR) begin
      lbase = PH_REST;
    end else begin
      lbase = phase_q;
    end
    ln_left = left_q;
    ln_ovf  = ovf_q;
    if (lbase == PH_SKIP) begin
      if (is_cr) begin
        ln_phase = PH_SKIP_CR;
      end else if (is_blank) begin
        ln_phase = PH_SKIP;
      end else if (is_hex) begin
        ln_phase = PH_DIGITS;
        ln_left  = dig_left;
        ln_ovf   = dig_ovf;
      end else begin
        ln_phase = PH_REST;
      end
    end else if (lbase == PH_DIGITS && is_hex) begin
      ln_phase = PH_DIGITS;
      ln_left  = dig_left;
      ln_ovf   = dig_ovf;
    end else begin
      ln_phase = is_cr ? PH_REST_CR : PH_REST;
    end
  end

  assign left_dec = left_q - SIZE_BITS'(1);

  // Step the decoder by one byte
  always_comb begin
    phase_d = phase_q;
    left_d  = left_q;
    ovf_d   = ovf_q;
    fin_d   = fin_q;
    has     = 1'b0;
    st      = ST_RUN;

    if (fin_q) begin
      // Drop bytes until the end flag rearms the block
      if (eob) begin
        phase_d = PH_SKIP;
        left_d  = '0;
        ovf_d   = 1'b0;
        fin_d   = 1'b0;
      end
    end else begin
      unique case (phase_q)
        PH_SKIP_CR, PH_REST_CR: begin
          if (b == CHAR_LF) begin
            if (left_q == '0) begin
              st = ST_DONE;
            end else if (ovf_q) begin
              st = ST_TRUNC;
            end else begin
              phase_d = PH_DATA;
            end
          end else begin
            phase_d = ln_phase;
            left_d  = ln_left;
            ovf_d   = ln_ovf;
          end
        end
        PH_DATA: begin
          has    = 1'b1;
          left_d = left_dec;
          if (left_dec == '0) begin
            phase_d = PH_DATA_CR;
          end
        end
        PH_DATA_CR: begin
          if (is_cr) begin
            phase_d = PH_DATA_LF;
          end else begin
            st = ST_NOCRLF;
          end
        end
        PH_DATA_LF: begin
          if (b == CHAR_LF) begin
            phase_d = PH_SKIP;
            left_d  = '0;
            ovf_d   = 1'b0;
          end else begin
            st = ST_NOCRLF;
          end
        end
        default: begin
          phase_d = ln_phase;
          left_d  = ln_left;
          ovf_d   = ln_ovf;
        end
      endcase

      // End of buffer before the body is complete
      if (st == ST_RUN && eob) begin
        if (phase_d == PH_DATA) begin
          st = ST_TRUNC;
        end else if (phase_d == PH_DATA_CR || phase_d == PH_DATA_LF) begin
          st = ST_NOCRLF;
        end else begin
          st = ST_LINE;
        end
      end

      // After a status, rearm at once on the end flag, else wait for it
      if (st != ST_RUN) begin
        if (eob) begin
          phase_d = PH_SKIP;
          left_d  = '0;
          ovf_d   = 1'b0;
          fin_d   = 1'b0;
        end else begin
          fin_d = 1'b1;
        end
      end
    end
  end

  // Advance state only when the byte is consumed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SKIP;
      left_q  <= '0;
      ovf_q   <= 1'b0;
      fin_q   <= 1'b0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      left_q  <= left_d;
      ovf_q   <= ovf_d;
      fin_q   <= fin_d;
    end
  end

  assign res_o.valid             = slot_i.valid && (has || st != ST_RUN);
  assign res_o.item.has_data     = has;
  assign res_o.item.payload_byte = has ? b : 8'd0;
  assign res_o.item.status       = st;

endmodule

`default_nettype wire

[hdl/chdec_out_stage.sv]
// Output register of the chunked body decoder.
`default_nettype none

module chdec_out_stage (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   fire_i,
  input  chdec_pkg::chdec_res_t  res_i,
  output logic                   ready_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output chdec_pkg::chdec_out_t  out_data_o
);
  import chdec_pkg::*;

  logic       valid_q, valid_d;
  chdec_out_t item_q;
  logic       load;

  // Free when empty or when the held result leaves this cycle
  assign ready_o = !valid_q || !out_stall_i;
  assign load    = fire_i && res_i.valid;

  always_comb begin
    if (load) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold the result until its transfer
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= res_i.item;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = item_q;

endmodule

`default_nettype wire

[hdl/http_chunked_body_decoder_unit.sv]
// Top level of the HTTP chunked body decoder.
// Usage:
//   Input channel: one raw body byte per transfer (in_valid_i, in_stall_o,
//   in_data_i); set end_of_body on the last byte of a received buffer.
//   Output channel: at most one result per byte (out_valid_o, out_stall_i,
//   out_data_o). A result carries a payload byte (has_data), a status, or
//   both. Bytes of the size lines and CRLFs give a result only with a status.
//   Path: a transferred byte is captured in the input register, then decoded
//   into the output register. Throughput is one byte per cycle while the
//   receiver does not stall, set by the framing state update between the
//   two registers.
//   When the receiver stalls a held result, the decoder does not advance;
//   in_stall_o is high while the input register holds a byte behind it.
//   Any nonzero status ends the body; the consumer drops all payload of the
//   buffer on an error status. Bytes after a status are dropped until one
//   with end_of_body, which rearms the decoder.
//   Reset clears the valid flags of both registers and returns the decoder
//   to the start of a size line with a zero size.
`default_nettype none

module http_chunked_body_decoder_unit #(
  parameter int SIZE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  chdec_pkg::chdec_in_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output chdec_pkg::chdec_out_t out_data_o
);
  import chdec_pkg::*;

  chdec_in_slot_t slot;
  chdec_res_t     res;
  logic           out_ready;
  logic           fire;

  // Consume the registered byte when the output side can take its result
  assign fire = slot.valid && out_ready;

  chdec_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .advance_i  (out_ready),
    .slot_o     (slot)
  );

  chdec_fsm #(
    .SIZE_BITS (SIZE_BITS)
  ) u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .slot_i (slot),
    .res_o  (res)
  );

  chdec_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .res_i       (res),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

[hdl/chdec_checker.sv]
// Port-level checks of the chunked body decoder, bound to the top level.
`default_nettype none
`include "http_chunked_body_decoder_unit_defines.svh"

module chdec_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input chdec_pkg::chdec_out_t out_data_o
);
  import chdec_pkg::*;

  // Stalled result stays put
  `CHDEC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled result changed")

  // Status stays within its defined codes
  `CHDEC_ASSERT_NOW(a_status_range, clk_i, rst_ni, out_valid_o, out_data_o.status <= ST_NOCRLF, "status code out of range")

  // A result without data must carry a status and a zero byte
  `CHDEC_ASSERT_NOW(a_empty_result, clk_i, rst_ni, out_valid_o && !out_data_o.has_data, out_data_o.status != ST_RUN && out_data_o.payload_byte == 8'd0, "empty result")

  // Payload bytes never come with done or a size line error
  `CHDEC_ASSERT_NOW(a_data_status, clk_i, rst_ni, out_valid_o && out_data_o.has_data, out_data_o.status == ST_RUN || out_data_o.status == ST_TRUNC || out_data_o.status == ST_NOCRLF, "bad status with data")

endmodule

bind http_chunked_body_decoder_unit chdec_checker u_chdec_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

[sim/http_chunked_body_decoder_unit_tb.sv]
// Self-checking testbench for the HTTP chunked body decoder unit.
`timescale 1ns / 100ps

module http_chunked_body_decoder_unit_tb;
  import chdec_pkg::*;

  localparam int SIZE_W      = 32;
  localparam int RANDOM_LEN  = 1650;
  localparam int IDLE_LIMIT  = 400;
  localparam int DRAIN_WAIT  = 8;
  localparam int MAX_WAIT    = 18;
  localparam int PRINT_LIMIT = 50;

  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_RESULT
  } row_check_e;

  typedef struct {
    chdec_in_t  item;
    row_check_e check;
    chdec_out_t res;
  } dir_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  chdec_in_t  in_data_i;
  logic       out_valid_o;
  logic       out_stall_i;
  chdec_out_t out_data_o;

  // Decoder state mirrored by the predictor
  logic [2:0]        dec_phase;
  logic [SIZE_W-1:0] size_left;
  logic              size_ovf;
  logic              body_closed;

  chdec_out_t expected_q[$];
  chdec_in_t  body_q[$];
  dir_row_t   dir_rows[$];

  int  mismatches;
  int  bytes_sent;
  int  buffers_sent;
  int  results_seen;
  int  payload_seen;
  int  status_seen[8];
  int  idle_cycles;
  int  stall_left;
  bit  steady;

  http_chunked_body_decoder_unit #(
    .SIZE_BITS(SIZE_W)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #10 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_LIMIT) begin
      $display("[%0t] mismatch at result %0d: %s", $realtime, results_seen, msg);
    end
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Chunked decoding predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_decoder();
    dec_phase   = PH_SKIP;
    size_left   = '0;
    size_ovf    = 1'b0;
    body_closed = 1'b0;
  endfunction

  // Shift one hex digit into the size; saturate once it no longer fits
  function automatic void add_size_digit(logic [3:0] d);
    if (size_ovf) return;
    if (size_left[SIZE_W-1 -: 4] != 4'h0) begin
      size_ovf  = 1'b1;
      size_left = '1;
    end else begin
      size_left = {size_left[SIZE_W-5:0], d};
    end
  endfunction

  // Advance the size-line scan by one byte that is not a line end
  function automatic void scan_line_byte(logic [7:0] b);
    int d;
    if (b >= "0" && b <= "9") d = int'(b - 8'h30);
    else if (b >= "a" && b <= "f") d = int'(b - 8'h57);
    else if (b >= "A" && b <= "F") d = int'(b - 8'h37);
    else d = -1;
    case (dec_phase)
      PH_SKIP: begin
        if (b == CHAR_CR) begin
          dec_phase = PH_SKIP_CR;
        end else if (b == CHAR_SPACE || (b >= CHAR_TAB && b <= CHAR_CR)) begin
          dec_phase = PH_SKIP;
        end else if (d >= 0) begin
          add_size_digit(4'(d));
          dec_phase = PH_DIGITS;
        end else begin
          dec_phase = PH_REST;
        end
      end
      PH_DIGITS: begin
        if (d >= 0) add_size_digit(4'(d));
        else dec_phase = (b == CHAR_CR) ? PH_REST_CR : PH_REST;
      end
      default: begin
        dec_phase = (b == CHAR_CR) ? PH_REST_CR : PH_REST;
      end
    endcase
  endfunction

  // Decode one accepted byte; return 1 when it produces a result
  function automatic bit decode_byte(input chdec_in_t it, output chdec_out_t res);
    logic [2:0] st;
    logic [7:0] b;
    b   = it.body_byte;
    st  = ST_RUN;
    res = '0;
    if (body_closed) begin
      if (it.end_of_body) clear_decoder();
      return 1'b0;
    end
    case (dec_phase)
      PH_SKIP_CR, PH_REST_CR: begin
        if (b == CHAR_LF) begin
          if (size_left == '0) st = ST_DONE;
          else if (size_ovf) st = ST_TRUNC;
          else dec_phase = PH_DATA;
        end else begin
          dec_phase = (dec_phase == PH_SKIP_CR) ? PH_SKIP : PH_REST;
          scan_line_byte(b);
        end
      end
      PH_DATA: begin
        res.has_data     = 1'b1;
        res.payload_byte = b;
        size_left        = size_left - 1'b1;
        if (size_left == '0) dec_phase = PH_DATA_CR;
      end
      PH_DATA_CR: begin
        if (b == CHAR_CR) dec_phase = PH_DATA_LF;
        else st = ST_NOCRLF;
      end
      PH_DATA_LF: begin
        if (b == CHAR_LF) begin
          dec_phase = PH_SKIP;
          size_left = '0;
          size_ovf  = 1'b0;
        end else begin
          st = ST_NOCRLF;
        end
      end
      default: begin
        scan_line_byte(b);
      end
    endcase
    // Classify an early end of the buffer by where it falls
    if (st == ST_RUN && it.end_of_body) begin
      if (dec_phase == PH_DATA) st = ST_TRUNC;
      else if (dec_phase == PH_DATA_CR || dec_phase == PH_DATA_LF) st = ST_NOCRLF;
      else st = ST_LINE;
    end
    if (st != ST_RUN) begin
      if (it.end_of_body) clear_decoder();
      else body_closed = 1'b1;
    end
    res.status = st;
    return res.has_data || st != ST_RUN;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------

  function automatic void add_row(logic [7:0] b, bit eob, row_check_e check = CHK_MODEL,
                                  logic has = 1'b0, logic [7:0] pay = 8'h00,
                                  logic [2:0] st = ST_RUN);
    dir_row_t row;
    row.item.body_byte    = b;
    row.item.end_of_body  = eob;
    row.check             = check;
    row.res.has_data      = has;
    row.res.payload_byte  = pay;
    row.res.status        = st;
    dir_rows.push_back(row);
  endfunction

  function automatic void push_byte(logic [7:0] b);
    chdec_in_t it;
    it.body_byte   = b;
    it.end_of_body = 1'b0;
    body_q.push_back(it);
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] d);
    logic [7:0] c;
    c = (d < 4'd10) ? 8'h30 + 8'(d) : 8'h57 + 8'(d);
    if (d >= 4'd10 && $urandom_range(0, 1)) c = c - 8'h20;
    return c;
  endfunction

  function automatic void push_hex(logic [31:0] v);
    bit lead;
    lead = 1'b1;
    for (int i = 7; i >= 0; i--) begin
      if (v[4*i +: 4] != 4'h0 || i == 0) lead = 1'b0;
      if (!lead) push_byte(hex_char(v[4*i +: 4]));
    end
  endfunction

  // Leading blanks, sometimes with a CR that is not followed by LF
  function automatic void push_blanks();
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(0, 4))
        0: push_byte(CHAR_SPACE);
        1: push_byte(CHAR_TAB);
        2: push_byte(CHAR_LF);
        3: begin
          push_byte(CHAR_CR);
          push_byte(CHAR_SPACE);
        end
        default: push_byte(8'($urandom_range(11, 12)));
      endcase
    end
  endfunction

  function automatic void push_ext();
    case ($urandom_range(0, 3))
      0: push_text(";name=v");
      1: push_text(" ;x");
      default: ;
    endcase
  endfunction

  function automatic void push_crlf();
    push_byte(CHAR_CR);
    push_byte(CHAR_LF);
  endfunction

  // Append one buffer: mostly a well-formed body, some noise and damage
  function automatic void build_body();
    int          first;
    int          chunks;
    int          idx;
    bit          cut_short;
    logic [31:0] sz;
    first     = body_q.size();
    cut_short = 1'b0;
    if ($urandom_range(0, 11) == 0) begin
      repeat ($urandom_range(1, 12)) push_byte(8'($urandom_range(0, 255)));
    end else begin
      chunks = $urandom_range(0, 3);
      for (int c = 0; c < chunks; c++) begin
        push_blanks();
        case ($urandom_range(0, 11))
          0: begin
            // size too wide for the counter
            push_byte(hex_char(4'($urandom_range(1, 15))));
            repeat ($urandom_range(8, 10)) push_byte(hex_char(4'($urandom_range(0, 15))));
            push_ext();
            push_crlf();
            cut_short = 1'b1;
          end
          1: begin
            // huge size, buffer ends inside the payload
            sz = $urandom | 32'h1000_0000;
            push_hex(sz);
            push_ext();
            push_crlf();
            repeat ($urandom_range(1, 5)) push_byte(8'($urandom_range(0, 255)));
            cut_short = 1'b1;
          end
          default: begin
            sz = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            repeat ($urandom_range(0, 2)) push_byte("0");
            push_hex(sz);
            push_ext();
            push_crlf();
            repeat (sz) push_byte(8'($urandom_range(0, 255)));
            push_crlf();
          end
        endcase
        if (cut_short) break;
      end
      if (!cut_short) begin
        push_blanks();
        case ($urandom_range(0, 7))
          0: ;
          1: push_text("+5");
          2: push_text("-3");
          3: push_text("0x1f");
          4: push_text("000");
          default: push_byte("0");
        endcase
        push_ext();
        push_crlf();
        repeat ($urandom_range(0, 4)) push_byte(8'($urandom_range(0, 255)));
      end
    end
    // Damage some buffers: flip one byte or end the buffer early
    case ($urandom_range(0, 5))
      0: begin
        idx = $urandom_range(first, body_q.size() - 1);
        body_q[idx].body_byte = 8'($urandom_range(0, 255));
      end
      1: begin
        idx = $urandom_range(first, body_q.size() - 1);
        while (body_q.size() > idx + 1) void'(body_q.pop_back());
      end
      default: ;
    endcase
    body_q[body_q.size() - 1].end_of_body = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Transfer one byte after a random gap, then record what it should produce
  task automatic send_item(input chdec_in_t it, input row_check_e check,
                           input chdec_out_t typed);
    int         gap;
    bit         got;
    chdec_out_t res;
    if ($urandom_range(0, 79) == 0) steady = !steady;
    gap = steady ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
    if (it.end_of_body) buffers_sent++;
    got = decode_byte(it, res);
    case (check)
      CHK_MODEL:  if (got) expected_q.push_back(res);
      CHK_RESULT: expected_q.push_back(typed);
      default:    ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Output side: check results, stall at random, watch for a hang
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : result_check
    chdec_out_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result %p", out_data_o));
        end else begin
          want = expected_q.pop_front();
          if (out_data_o.has_data !== want.has_data)
            report_mismatch($sformatf("has_data %b, want %b",
                                      out_data_o.has_data, want.has_data));
          if (out_data_o.payload_byte !== want.payload_byte)
            report_mismatch($sformatf("payload_byte %h, want %h",
                                      out_data_o.payload_byte, want.payload_byte));
          if (out_data_o.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d",
                                      out_data_o.status, want.status));
        end
        results_seen++;
        if (out_data_o.has_data === 1'b1) payload_seen++;
        if (!$isunknown(out_data_o.status)) status_seen[out_data_o.status]++;
        stall_left = steady ? 0 : $urandom_range(0, MAX_WAIT);
      end
      out_stall_i <= (stall_left > 0);
      if (stall_left > 0) stall_left--;

      // End the run when no transfer happens for too long
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
          $display("FAILED: results differ");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    rst_ni      = 1'b0;
    mismatches  = 0;
    idle_cycles = 0;
    stall_left  = 0;
    steady      = 1'b0;
    clear_decoder();

    // Blanks with a lone CR, digit, extension, two payload bytes at the extremes
    add_row(CHAR_SPACE, 1'b0);
    add_row(CHAR_CR, 1'b0);
    add_row(CHAR_TAB, 1'b0);
    add_row("2", 1'b0);
    add_row("x", 1'b0);
    add_row(CHAR_CR, 1'b0);
    add_row(CHAR_LF, 1'b0);
    add_row(8'h00, 1'b0, CHK_RESULT, 1'b1, 8'h00, ST_RUN);
    add_row(8'hff, 1'b0, CHK_RESULT, 1'b1, 8'hff, ST_RUN);
    add_row(CHAR_CR, 1'b0);
    add_row(CHAR_LF, 1'b0);
    // Zero chunk, then a trailer byte with the end flag rearms
    add_row("0", 1'b0);
    add_row(CHAR_CR, 1'b0);
    add_row(CHAR_LF, 1'b0, CHK_RESULT, 1'b0, 8'h00, ST_DONE);
    add_row("z", 1'b1, CHK_NONE);
    // A sign counts as no digits
    add_row("-", 1'b0);
    add_row(CHAR_CR, 1'b0);
    add_row(CHAR_LF, 1'b0, CHK_RESULT, 1'b0, 8'h00, ST_DONE);
    add_row(8'h80, 1'b1, CHK_NONE);
    // End flag inside a size line
    add_row("1", 1'b1, CHK_RESULT, 1'b0, 8'h00, ST_LINE);
    // Nonzero size line ending on the end flag
    add_row("A", 1'b0);
    add_row(CHAR_CR, 1'b0);
    add_row(CHAR_LF, 1'b1, CHK_RESULT, 1'b0, 8'h00, ST_TRUNC);
    // Bad byte where the CR after data belongs
    add_row("1", 1'b0);
    add_row(CHAR_CR, 1'b0);
    add_row(CHAR_LF, 1'b0);
    add_row("a", 1'b0, CHK_RESULT, 1'b1, "a", ST_RUN);
    add_row("x", 1'b0, CHK_RESULT, 1'b0, 8'h00, ST_NOCRLF);
    add_row("y", 1'b1, CHK_NONE);
    // End flag inside payload
    add_row("2", 1'b0);
    add_row(CHAR_CR, 1'b0);
    add_row(CHAR_LF, 1'b0);
    add_row("p", 1'b1, CHK_RESULT, 1'b1, "p", ST_TRUNC);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed table
    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].check, dir_rows[i].res);

    // Random buffers
    while (body_q.size() < RANDOM_LEN) build_body();
    foreach (body_q[i]) send_item(body_q[i], CHK_MODEL, '0);
    in_valid_i <= 1'b0;

    // Drain outstanding results, then let the pipeline settle
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Sent %0d body bytes in %0d buffers; checked %0d results, %0d with payload.",
             bytes_sent, buffers_sent, results_seen, payload_seen);
    $display("Status seen: done %0d, size line %0d, truncated %0d, missing CRLF %0d.",
             status_seen[ST_DONE], status_seen[ST_LINE], status_seen[ST_TRUNC],
             status_seen[ST_NOCRLF]);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
